// ===== sv/lds_pkg.sv =====
// Package for the linear Diophantine solver.
// Types, constants and controller state encoding; no dependencies.
package lds_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH       = 32;
   localparam int RESULT_WIDTH      = 64;
   localparam int QSTACK_DEPTH      = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_DSTEP,
      ST_BACK,
      ST_CDIV,
      ST_MUL,
      ST_SIGN,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic div_for_c;
      logic push;
      logic back_step;
      logic mul_step;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic p_zero;
      logic div_done;
      logic stack_empty;
      logic mul_done;
   } status_type;

   // input item: a*x + b*y = c
   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] coef_a;
      logic signed [FIELD_WIDTH-1:0] coef_b;
      logic signed [FIELD_WIDTH-1:0] rhs_c;
   } req_item_type;

   // result item
   typedef struct packed {
      logic                           solvable;
      logic signed [RESULT_WIDTH-1:0] x_solution;
      logic signed [RESULT_WIDTH-1:0] y_solution;
      logic [FIELD_WIDTH-1:0]         gcd_value;
   } rsp_item_type;

endpackage

// ===== sv/lds_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
interface lds_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lds_ctrl.sv =====
// Controller state machine of the linear Diophantine solver.
// Depends on lds_pkg.
module lds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  lds_pkg::status_type status,
   output lds_pkg::cmd_type    cmd
);
   import lds_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.p_zero) begin
               state_in = ST_BACK;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DSTEP;
            end
         end
         ST_DSTEP: begin
            // record quotient, shift remainders
            cmd.push = 1'b1;
            state_in = ST_LOAD;
         end
         ST_BACK: begin
            if (status.stack_empty) begin
               cmd.div_start = 1'b1;
               cmd.div_for_c = 1'b1;
               state_in      = ST_CDIV;
            end else begin
               cmd.back_step = 1'b1;
            end
         end
         ST_CDIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_for_c = 1'b1;
            if (status.div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_done) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== sv/lds_datapath.sv =====
// Datapath: Euclid registers, shared restoring divider, quotient stack,
// back-substitution and a 64x16 partial-product multiplier. Depends on lds_pkg.
module lds_datapath #(
   parameter int OPERAND_WIDTH = lds_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic signed [lds_pkg::FIELD_WIDTH-1:0] coef_a,
   input  logic signed [lds_pkg::FIELD_WIDTH-1:0] coef_b,
   input  logic signed [lds_pkg::FIELD_WIDTH-1:0] rhs_c,
   input  lds_pkg::cmd_type                      cmd,
   output lds_pkg::status_type                   status,
   output logic                                  solvable,
   output logic signed [lds_pkg::RESULT_WIDTH-1:0] x_solution,
   output logic signed [lds_pkg::RESULT_WIDTH-1:0] y_solution,
   output logic [lds_pkg::FIELD_WIDTH-1:0]       gcd_value
);
   import lds_pkg::*;

   localparam int MW  = OPERAND_WIDTH + 1;          // magnitude width
   localparam int CW  = $clog2(MW + 1);             // divider bit counter
   localparam int SW  = $clog2(QSTACK_DEPTH);
   localparam int RW  = RESULT_WIDTH;
   localparam int HW  = RW / 4;                     // multiplier digit width
   localparam int NPP = 4;
   localparam int MCW = $clog2(NPP + 1);            // multiply step counter
   localparam logic [SW:0] SP_ONE = (SW+1)'(1);

   // operand capture
   logic [MW-1:0] p_ff, q_ff, cmag_ff;
   logic          a_neg_ff, b_neg_ff, c_neg_ff;
   logic [OPERAND_WIDTH-1:0] a_lo, b_lo, c_lo;
   logic [MW-1:0] a_ext, b_ext, c_ext;

   assign a_lo  = coef_a[OPERAND_WIDTH-1:0];
   assign b_lo  = coef_b[OPERAND_WIDTH-1:0];
   assign c_lo  = rhs_c[OPERAND_WIDTH-1:0];
   assign a_ext = {a_lo[OPERAND_WIDTH-1], a_lo};
   assign b_ext = {b_lo[OPERAND_WIDTH-1], b_lo};
   assign c_ext = {c_lo[OPERAND_WIDTH-1], c_lo};

   // restoring divider: one quotient bit a cycle
   logic [MW-1:0] dv_num_ff, dv_den_ff, dv_quo_ff, dv_rem_ff;
   logic [CW-1:0] dv_cnt_ff;
   logic [MW:0]   dv_trial;
   logic [MW:0]   dv_shift;

   assign dv_shift = {dv_rem_ff, dv_num_ff[MW-1]};
   assign dv_trial = dv_shift - {1'b0, dv_den_ff};

   // quotient stack
   logic [MW-1:0] qstack [QSTACK_DEPTH];
   logic [SW:0]   sp_ff;
   logic [MW-1:0] top_ff;

   // Bezout accumulators, modulo 2^64
   logic [RW-1:0] u_ff, v_ff;
   logic [RW-1:0] k_ff;
   logic          ok_ff;

   // raw coefficients saved before scaling shifts them
   logic [RW-1:0] u_unsc_ff, v_unsc_ff;

   // multiplier: u*k and v*k over NPP digit steps
   logic [RW-1:0] acc_u_ff, acc_v_ff;
   logic [MCW-1:0] mcnt_ff;
   logic [HW-1:0] kd;
   logic [RW-1:0] pp_u, pp_v;
   logic [RW-1:0] back_mul;
   logic signed [2*MW+1:0] back_prod;

   assign kd   = k_ff[HW-1:0];
   assign pp_u = RW'(u_ff * {{(RW-HW){1'b0}}, kd});
   assign pp_v = RW'(v_ff * {{(RW-HW){1'b0}}, kd});

   // during back substitution |u| stays within 2^(OPERAND_WIDTH-1),
   // so its low MW+1 bits carry the full signed value
   assign back_prod = $signed(u_ff[MW:0]) * $signed({1'b0, top_ff});
   assign back_mul  = RW'(back_prod);

   always_ff @(posedge clock) begin
      // load a new item
      if (cmd.load) begin
         p_ff     <= a_ext[MW-1] ? MW'(-a_ext) : a_ext;
         q_ff     <= b_ext[MW-1] ? MW'(-b_ext) : b_ext;
         cmag_ff  <= c_ext[MW-1] ? MW'(-c_ext) : c_ext;
         a_neg_ff <= a_lo[OPERAND_WIDTH-1];
         b_neg_ff <= b_lo[OPERAND_WIDTH-1];
         c_neg_ff <= c_lo[OPERAND_WIDTH-1];
         sp_ff    <= '0;
         u_ff     <= '0;
         v_ff     <= RW'(1);
         mcnt_ff  <= '0;
      end

      // divider start: q/p for Euclid, cmag/g for the scale
      if (cmd.div_start) begin
         dv_num_ff <= cmd.div_for_c ? cmag_ff : q_ff;
         dv_den_ff <= cmd.div_for_c ? q_ff : p_ff;
         dv_rem_ff <= '0;
         dv_quo_ff <= '0;
         dv_cnt_ff <= CW'(MW);
      end else if (cmd.div_step && dv_cnt_ff != '0) begin
         dv_num_ff <= dv_num_ff << 1;
         dv_cnt_ff <= dv_cnt_ff - CW'(1);
         if (!dv_trial[MW]) begin
            dv_rem_ff <= dv_trial[MW-1:0];
            dv_quo_ff <= {dv_quo_ff[MW-2:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_shift[MW-1:0];
            dv_quo_ff <= {dv_quo_ff[MW-2:0], 1'b0};
         end
      end

      // record one Euclid step
      if (cmd.push) begin
         qstack[sp_ff[SW-1:0]] <= dv_quo_ff;
         sp_ff <= sp_ff + SP_ONE;
         q_ff  <= p_ff;
         p_ff  <= dv_rem_ff;
      end

      // back substitution: each quotient is first read from the stack, then used
      top_ff <= qstack[SW'(sp_ff - SP_ONE)];
      if (cmd.back_step) begin
         if (mcnt_ff == '0) begin
            mcnt_ff <= MCW'(1);
         end else begin
            u_ff    <= v_ff - back_mul;
            v_ff    <= u_ff;
            sp_ff   <= sp_ff - SP_ONE;
            mcnt_ff <= '0;
         end
      end

      // divider done for c: decide solvability and set the scale
      if (cmd.div_for_c && !cmd.div_start && dv_cnt_ff == '0) begin
         if (q_ff == '0) begin
            ok_ff <= (cmag_ff == '0);
            k_ff  <= '0;
         end else begin
            ok_ff <= (dv_rem_ff == '0);
            k_ff  <= c_neg_ff ? RW'(-{{(RW-MW){1'b0}}, dv_quo_ff})
                              : {{(RW-MW){1'b0}}, dv_quo_ff};
         end
         acc_u_ff <= '0;
         acc_v_ff <= '0;
         mcnt_ff  <= '0;
      end

      if (cmd.mul_step && mcnt_ff != MCW'(NPP)) begin
         acc_u_ff <= acc_u_ff + pp_u;
         acc_v_ff <= acc_v_ff + pp_v;
         k_ff     <= k_ff >> HW;
         u_ff     <= u_ff << HW;
         v_ff     <= v_ff << HW;
         mcnt_ff  <= mcnt_ff + MCW'(1);
      end

      // final selection and signs
      if (cmd.finish) begin
         solvable  <= ok_ff;
         gcd_value <= FIELD_WIDTH'(q_ff);
         if (q_ff == '0) begin
            x_solution <= '0;
            y_solution <= ok_ff ? '0 : RW'(1);
         end else if (ok_ff) begin
            x_solution <= a_neg_ff ? RW'(-acc_u_ff) : acc_u_ff;
            y_solution <= b_neg_ff ? RW'(-acc_v_ff) : acc_v_ff;
         end else begin
            x_solution <= u_unsc_ff;
            y_solution <= v_unsc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start && cmd.div_for_c) begin
         u_unsc_ff <= u_ff;
         v_unsc_ff <= v_ff;
      end
   end

   assign status.p_zero      = (p_ff == '0);
   assign status.div_done    = (dv_cnt_ff == '0) && !cmd.div_start;
   assign status.stack_empty = (sp_ff == '0);
   assign status.mul_done    = (mcnt_ff == MCW'(NPP));
endmodule

// ===== sv/linear_diophantine_solver.sv =====
// Linear Diophantine solver: extended Euclid with a bit-serial divider.
// Per item: the Euclid steps, the back-substitution steps, the c/g divide,
// the scaling multiply and the finish step.
// One item at a time; next item accepted the cycle after the result is taken.
// Reset (synchronous, active high) returns the controller to idle.
// Depends on lds_pkg, lds_if, lds_ctrl and lds_datapath.
module linear_diophantine_solver #(
   parameter int OPERAND_WIDTH = lds_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_coef_a,
   input  logic signed [31:0]          req_coef_b,
   input  logic signed [31:0]          req_rhs_c,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_solvable,
   output logic signed [63:0]          rsp_x_solution,
   output logic signed [63:0]          rsp_y_solution,
   output logic [31:0]                 rsp_gcd_value
);
   import lds_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic                           dp_solvable;
   logic signed [RESULT_WIDTH-1:0] dp_x_solution;
   logic signed [RESULT_WIDTH-1:0] dp_y_solution;
   logic [FIELD_WIDTH-1:0]         dp_gcd_value;

   // input and result channels
   lds_if #(.payload_type(req_item_type)) req_ch (.clock(clock));
   lds_if #(.payload_type(rsp_item_type)) rsp_ch (.clock(clock));

   assign req_ch.valid = req_valid;
   assign req_ch.data  = {req_coef_a, req_coef_b, req_rhs_c};
   assign req_ready    = req_ch.ready;

   assign rsp_ch.ready = rsp_ready;
   assign rsp_ch.data  = {dp_solvable, dp_x_solution, dp_y_solution, dp_gcd_value};
   assign rsp_valid      = rsp_ch.valid;
   assign rsp_solvable   = rsp_ch.data.solvable;
   assign rsp_x_solution = rsp_ch.data.x_solution;
   assign rsp_y_solution = rsp_ch.data.y_solution;
   assign rsp_gcd_value  = rsp_ch.data.gcd_value;

   lds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lds_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
      .clock      (clock),
      .coef_a     (req_ch.data.coef_a),
      .coef_b     (req_ch.data.coef_b),
      .rhs_c      (req_ch.data.rhs_c),
      .cmd        (cmd),
      .status     (status),
      .solvable   (dp_solvable),
      .x_solution (dp_x_solution),
      .y_solution (dp_y_solution),
      .gcd_value  (dp_gcd_value)
   );
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for linear_diophantine_solver: directed and random items,
// predicted in place by an extended Euclid solver. Depends on the RTL in sv/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] rhs_c;
   } equation_type;

   typedef struct {
      logic        solvable;
      logic [63:0] x_solution;
      logic [63:0] y_solution;
      logic [31:0] gcd_value;
   } solution_type;

   localparam int STALL_LIMIT = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_coef_a = '0;
   logic signed [31:0] req_coef_b = '0;
   logic signed [31:0] req_rhs_c = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_solvable;
   logic signed [63:0] rsp_x_solution;
   logic signed [63:0] rsp_y_solution;
   logic [31:0] rsp_gcd_value;

   equation_type equations_pending[$];
   solution_type solutions_expected[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int items_solved_ok = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;
   bit long_hold = 1'b0;
   bit req_accepted = 1'b0;

   always #5 clock = ~clock;

   linear_diophantine_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_rhs_c(req_rhs_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_solvable(rsp_solvable), .rsp_x_solution(rsp_x_solution),
      .rsp_y_solution(rsp_y_solution), .rsp_gcd_value(rsp_gcd_value)
   );

   // Extended Euclid on magnitudes, mod 2^64 back substitution, then scaling by c/g.
   function automatic solution_type solve_equation(equation_type eq);
      logic [63:0] a, b, c, p, q, r, u, v, nu, g, cmag, k;
      logic [63:0] quot[$];
      solution_type s;
      a = {{32{eq.coef_a[31]}}, eq.coef_a};
      b = {{32{eq.coef_b[31]}}, eq.coef_b};
      c = {{32{eq.rhs_c[31]}}, eq.rhs_c};
      p = a[63] ? -a : a;
      q = b[63] ? -b : b;
      u = 64'd0;
      v = 64'd1;
      while (p != 0) begin
         r = q % p;
         quot = {quot, q / p};
         q = p;
         p = r;
      end
      g = q;
      while (quot.size() > 0) begin
         nu = v - quot.pop_back() * u;
         v = u;
         u = nu;
      end
      cmag = c[63] ? -c : c;
      if (g == 0) begin
         s.solvable = (cmag == 0);
         if (s.solvable) begin
            u = 0;
            v = 0;
         end
      end else if (cmag % g != 0) begin
         s.solvable = 1'b0;
      end else begin
         s.solvable = 1'b1;
         k = cmag / g;
         if (c[63]) k = -k;
         u = u * k;
         v = v * k;
         if (a[63]) u = -u;
         if (b[63]) v = -v;
      end
      s.x_solution = u;
      s.y_solution = v;
      s.gcd_value = g[31:0];
      return s;
   endfunction

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 255) - 128;
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         3: return $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
         default: return $urandom_range(0, 65535) * (($urandom_range(0, 1)) ? 1 : -1);
      endcase
   endfunction

   task automatic add_equation(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c);
      equation_type eq;
      eq.coef_a = a;
      eq.coef_b = b;
      eq.rhs_c = c;
      equations_pending = {equations_pending, eq};
   endtask

   // Directed corners, then random equations; many scale a, b and c by a shared random factor.
   initial begin
      logic [31:0] f, a, b, c;
      add_equation(0, 0, 0);
      add_equation(0, 0, 5);
      add_equation(0, 0, 32'h8000_0000);
      add_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_equation(32'h8000_0000, 0, 32'h8000_0000);
      add_equation(0, 32'h8000_0000, 7);
      add_equation(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      add_equation(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      add_equation(7, 0, -14);
      add_equation(0, -9, 27);
      add_equation(6, 4, 3);
      add_equation(-6, 4, 10);
      add_equation(6, -4, -10);
      add_equation(-6, -4, 32'h7fff_fffe);
      add_equation(1836311903, 1134903170, 1);
      add_equation(-1836311903, 1134903170, -123456789);
      add_equation(32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0000);
      add_equation(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
      repeat (352) begin
         a = random_operand();
         b = random_operand();
         if ($urandom_range(0, 2) != 0) begin
            f = $urandom_range(1, 1000);
            c = (random_operand() % 2000000) * f;
            a = (a % 2000000) * f;
            b = (b % 2000000) * f;
         end else begin
            c = random_operand();
         end
         add_equation(a, b, c);
      end
   end

   // Reset once, then wait for all items to drain.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (stimulus_done && solutions_expected.size() == 0);
      repeat (20) @(posedge clock);
      $display("Ran %0d equations, %0d solvable, incl. zero, extreme and mixed-sign cases.",
               items_sent, items_solved_ok);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("linear_diophantine_solver regression: pass");
      else
         $display("linear_diophantine_solver regression: fail");
      $finish;
   end

   // Driver: offers items at falling edges, with random gaps.
   always @(negedge clock) begin : driver
      static int gap = 0;
      equation_type eq;
      bit took;
      if (!reset) begin
         // acceptance is seen by the monitor at the rising edge
         took = req_accepted;
         req_accepted = 1'b0;
         if (took) gap = gap_length();
         if (req_valid && !took) begin
            // hold current item until accepted
         end else if (gap > 0) begin
            gap--;
            req_valid <= 1'b0;
         end else if (equations_pending.size() > 0) begin
            eq = equations_pending.pop_front();
            req_coef_a <= eq.coef_a;
            req_coef_b <= eq.coef_b;
            req_rhs_c <= eq.rhs_c;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            stimulus_done = 1'b1;
         end
      end
   end

   // Receiver back-pressure, including one long hold-off early in the run.
   always @(negedge clock) begin : receiver
      static int stall = 0;
      static int hold_count = 0;
      if (!reset) begin
         if (!long_hold && items_sent == 3) begin
            long_hold = 1'b1;
            hold_count = 5000;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall = gap_length();
         end
      end
   end

   // Monitor and watchdog at rising edges.
   always @(posedge clock) begin : monitor
      solution_type exp_s;
      equation_type eq;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         // accepted input item: predict its result
         if (req_valid && req_ready) begin
            eq.coef_a = req_coef_a;
            eq.coef_b = req_coef_b;
            eq.rhs_c = req_rhs_c;
            solutions_expected = {solutions_expected, solve_equation(eq)};
            items_sent++;
            req_accepted = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (solutions_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result item at %0t", $realtime);
            end else begin
               exp_s = solutions_expected.pop_front();
               if (exp_s.solvable) items_solved_ok++;
               if (rsp_solvable !== exp_s.solvable || rsp_x_solution !== exp_s.x_solution
                   || rsp_y_solution !== exp_s.y_solution
                   || rsp_gcd_value !== exp_s.gcd_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Mismatch: solvable %0b/%0b x %0d/%0d y %0d/%0d ",
                               "gcd %0d/%0d (expected/actual)"},
                              exp_s.solvable, rsp_solvable,
                              $signed(exp_s.x_solution), rsp_x_solution,
                              $signed(exp_s.y_solution), rsp_y_solution,
                              exp_s.gcd_value, rsp_gcd_value);
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("linear_diophantine_solver regression: fail");
            $finish;
         end
      end
   end
endmodule
